// ===== rtl/hbs_pkg.sv =====
// Shared types and constants for the heightmap bilinear sampler.
// Used by the front end, the back end and the top level.
// No dependencies.
package hbs_pkg;

   // Item opcodes as seen on the request channel.
   localparam logic OP_QUERY = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_RES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_CELL  = 2'd2;

   // Configuration reset values.
   localparam logic [7:0]  GRID_RES_RST  = 8'd255;
   localparam logic [22:0] HALF_SIZE_RST = 23'd0;
   localparam logic [23:0] INV_CELL_RST  = 24'd65536;

   // Output height limits, signed 24 bit.
   localparam int OUT_MAX = 8388607;
   localparam int OUT_MIN = -8388608;

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH) + 1;

   // What the back end has to do with one item.
   typedef enum logic [1:0] {
      CMD_NULL,   // answer zero, touch nothing
      CMD_STORE,  // store one grid height, answer zero
      CMD_QUERY   // read four corners and blend
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   x0;
      logic [7:0]   z0;
      logic [7:0]   fx;
      logic [7:0]   fz;
   } cmd_type;

   // Back end sequencer states.
   typedef enum logic [3:0] {
      BK_IDLE,
      BK_STORE,
      BK_NULL,
      BK_RD0,
      BK_RD1,
      BK_RD2,
      BK_RD3,
      BK_BL0,
      BK_BL1,
      BK_BL2,
      BK_BL3,
      BK_BL4
   } back_state_type;

endpackage

// ===== rtl/hbs_ram.sv =====
// Generic single-port RAM with registered read data.
// Used by the back end for the height grid. No dependencies.
module hbs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One access per cycle: write and/or read at the same address.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/hbs_front.sv =====
// Front end: accepts request beats, maps world points to grid coordinates
// and classifies each item into a back end command. Depends on hbs_pkg.
module hbs_front import hbs_pkg::*; #(
   parameter int MAX_CELLS   = 255,
   parameter int HEIGHT_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic signed [23:0]     req_world_x,
   input  logic signed [23:0]     req_world_z,
   input  logic [7:0]             req_grid_x,
   input  logic [7:0]             req_grid_z,
   input  logic signed [23:0]     req_write_height,
   input  logic [7:0]             grid_resolution,
   input  logic [22:0]            half_size,
   input  logic [23:0]            inv_cell_size,
   input  logic [QCNT_W-1:0]      q_count,
   output logic                   push,
   output cmd_type                push_cmd,
   output logic [HEIGHT_BITS-1:0] push_wdata
);

   localparam int RES_CAP = (MAX_CELLS < 255) ? MAX_CELLS : 255;
   localparam int WW      = (HEIGHT_BITS > 24) ? HEIGHT_BITS : 24;

   // Stage 1: offset sums.
   logic                   v1_ff, v1_in;
   logic                   op1_ff;
   logic signed [24:0]     sumx1_ff, sumx1_in;
   logic signed [24:0]     sumz1_ff, sumz1_in;
   logic [7:0]             gx1_ff, gz1_ff;
   logic [HEIGHT_BITS-1:0] wh1_ff, wh1_in;
   logic signed [WW-1:0]   wh_ext;

   // Stage 2: scaled coordinates.
   logic                   v2_ff;
   logic                   op2_ff;
   logic                   negx2_ff, negz2_ff;
   logic [31:0]            vx2_ff, vx2_in;
   logic [31:0]            vz2_ff, vz2_in;
   logic [47:0]            prodx, prodz;
   logic [7:0]             gx2_ff, gz2_ff;
   logic [HEIGHT_BITS-1:0] wh2_ff;

   logic [QCNT_W+1:0]      occupancy;
   logic [7:0]             res;
   logic [31:0]            limit;
   logic                   in_x, in_z, wr_ok;

   // Credit check: every item in the pipe has a queue slot reserved.
   assign occupancy = (QCNT_W+2)'(q_count) + (QCNT_W+2)'(v1_ff) + (QCNT_W+2)'(v2_ff);
   assign req_ready = (occupancy < (QCNT_W+2)'(QUEUE_DEPTH));
   assign v1_in     = req_valid & req_ready;

   // Add the half size to each world coordinate.
   assign sumx1_in = 25'(req_world_x) + signed'({2'b00, half_size});
   assign sumz1_in = 25'(req_world_z) + signed'({2'b00, half_size});
   assign wh_ext   = WW'(req_write_height);
   assign wh1_in   = wh_ext[HEIGHT_BITS-1:0];

   // Scale by the reciprocal cell size; a negative sum scales to zero.
   assign prodx  = 48'(sumx1_ff[23:0]) * 48'(inv_cell_size);
   assign prodz  = 48'(sumz1_ff[23:0]) * 48'(inv_cell_size);
   assign vx2_in = sumx1_ff[24] ? 32'd0 : prodx[47:16];
   assign vz2_in = sumz1_ff[24] ? 32'd0 : prodz[47:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
      end
      if (v1_in) begin
         op1_ff   <= req_op;
         sumx1_ff <= sumx1_in;
         sumz1_ff <= sumz1_in;
         gx1_ff   <= req_grid_x;
         gz1_ff   <= req_grid_z;
         wh1_ff   <= wh1_in;
      end
      op2_ff   <= op1_ff;
      negx2_ff <= sumx1_ff[24];
      negz2_ff <= sumz1_ff[24];
      vx2_ff   <= vx2_in;
      vz2_ff   <= vz2_in;
      gx2_ff   <= gx1_ff;
      gz2_ff   <= gz1_ff;
      wh2_ff   <= wh1_ff;
   end

   // Effective resolution and the inside tests.
   assign res   = (32'(grid_resolution) > RES_CAP) ? 8'(RES_CAP) : grid_resolution;
   assign limit = {16'd0, res, 8'd0};
   assign in_x  = (!negx2_ff || (inv_cell_size == 24'd0)) && (vx2_ff < limit);
   assign in_z  = (!negz2_ff || (inv_cell_size == 24'd0)) && (vz2_ff < limit);
   assign wr_ok = (gx2_ff <= res) && (gz2_ff <= res);

   // Build the command for the back end.
   always_comb begin
      push_cmd.x0 = vx2_ff[15:8];
      push_cmd.z0 = vz2_ff[15:8];
      push_cmd.fx = vx2_ff[7:0];
      push_cmd.fz = vz2_ff[7:0];
      if (op2_ff == OP_WRITE) begin
         push_cmd.x0   = gx2_ff;
         push_cmd.z0   = gz2_ff;
         push_cmd.kind = wr_ok ? CMD_STORE : CMD_NULL;
      end else begin
         push_cmd.kind = (in_x && in_z) ? CMD_QUERY : CMD_NULL;
      end
   end

   assign push       = v2_ff;
   assign push_wdata = wh2_ff;

endmodule

// ===== rtl/hbs_queue.sv =====
// Small register FIFO that decouples the front end from the back end.
// Generic in width and depth (depth a power of two). No dependencies.
module hbs_queue #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         push_data,
   input  logic                     pop,
   output logic [WIDTH-1:0]         head_data,
   output logic                     empty,
   output logic [$clog2(DEPTH):0]   count
);

   localparam int PTR_W = $clog2(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = slot_ff[rd_ptr_ff];
   assign empty     = (count_ff == '0);
   assign count     = count_ff;

endmodule

// ===== rtl/hbs_back.sv =====
// Back end: runs commands against the height memory, blends the four
// corners and holds the result beat. Depends on hbs_pkg and hbs_ram.
module hbs_back import hbs_pkg::*; #(
   parameter int MAX_CELLS   = 255,
   parameter int HEIGHT_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                head_cmd,
   input  logic [HEIGHT_BITS-1:0] head_wdata,
   input  logic                   q_empty,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [23:0]     rsp_height,
   output logic                   rsp_inside_res
);

   localparam int SIDE  = MAX_CELLS + 1;
   localparam int DEPTH = SIDE * SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam int HB    = HEIGHT_BITS;
   localparam int DW    = HB + 1;           // corner difference
   localparam int PW    = DW + 9;           // fraction times difference
   localparam int HW    = PW - 8;           // blended value before trimming
   localparam int CW    = (HW > 25) ? HW : 25;
   localparam logic signed [PW-1:0] ROUND  = PW'(128);
   localparam logic signed [CW-1:0] SAT_HI = CW'(OUT_MAX);
   localparam logic signed [CW-1:0] SAT_LO = CW'(OUT_MIN);

   back_state_type         state_ff, state_in;
   cmd_type                cur_ff, cur_in;
   logic [HB-1:0]          wdata_ff, wdata_in;
   logic signed [HB-1:0]   c00_ff, c00_in;
   logic signed [HB-1:0]   c01_ff, c01_in;
   logic signed [HB-1:0]   h0_ff, h0_in;
   logic signed [DW-1:0]   diff_ff, diff_in;
   logic signed [PW-1:0]   prod_ff, prod_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [23:0]     rsp_height_ff, rsp_height_in;
   logic                   rsp_inside_ff, rsp_inside_in;

   logic                   ram_we;
   logic [8:0]             ram_x, ram_z;
   logic [AW-1:0]          ram_addr;
   logic [HB-1:0]          ram_rdata;
   logic signed [HB-1:0]   rd_s;

   logic signed [HB-1:0]   a_sel;
   logic [7:0]             f_sel;
   logic signed [8:0]      f_s;
   logic signed [PW-1:0]   mul_out;
   logic signed [PW-1:0]   rsum;
   logic signed [HW-1:0]   rq;
   logic signed [HW-1:0]   blend_res;
   logic signed [CW-1:0]   fin_c;
   logic signed [23:0]     fin_sat;

   // Height grid, addressed z * SIDE + x.
   assign ram_addr = AW'(32'(ram_z) * SIDE + 32'(ram_x));
   assign rd_s     = ram_rdata;

   hbs_ram #(
      .WIDTH (HB),
      .DEPTH (DEPTH)
   ) u_hbs_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (wdata_ff),
      .rdata (ram_rdata)
   );

   // Shared blend unit: a + floor((f * diff + 128) / 256), one multiply per pass.
   always_comb begin
      priority case (state_ff)
         BK_BL0:  a_sel = c00_ff;
         BK_BL2:  a_sel = c01_ff;
         default: a_sel = h0_ff;
      endcase
      f_sel = (state_ff == BK_BL3) ? cur_ff.fz : cur_ff.fx;
   end

   assign f_s       = signed'({1'b0, f_sel});
   assign mul_out   = PW'(f_s) * PW'(diff_ff);
   assign rsum      = prod_ff + ROUND;
   assign rq        = rsum[PW-1:8];
   assign blend_res = HW'(a_sel) + rq;

   // Final value clipped to the signed 24 bit output range.
   assign fin_c   = CW'(blend_res);
   assign fin_sat = (fin_c > SAT_HI) ? 24'(SAT_HI) :
                    (fin_c < SAT_LO) ? 24'(SAT_LO) : fin_c[23:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff        <= cur_in;
      wdata_ff      <= wdata_in;
      c00_ff        <= c00_in;
      c01_ff        <= c01_in;
      h0_ff         <= h0_in;
      diff_ff       <= diff_in;
      prod_ff       <= prod_in;
      rsp_height_ff <= rsp_height_in;
      rsp_inside_ff <= rsp_inside_in;
   end

   // Sequencer: one memory access per cycle, then the blend passes.
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      wdata_in      = wdata_ff;
      c00_in        = c00_ff;
      c01_in        = c01_ff;
      h0_in         = h0_ff;
      diff_in       = diff_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_height_in = rsp_height_ff;
      rsp_inside_in = rsp_inside_ff;
      pop           = 1'b0;
      ram_we        = 1'b0;
      ram_x         = {1'b0, cur_ff.x0};
      ram_z         = {1'b0, cur_ff.z0};
      unique case (state_ff)
         BK_IDLE: begin
            // Take a command only when the result register will be free.
            if (!q_empty && (!rsp_valid_ff || rsp_ready)) begin
               pop      = 1'b1;
               cur_in   = head_cmd;
               wdata_in = head_wdata;
               unique case (head_cmd.kind)
                  CMD_STORE: state_in = BK_STORE;
                  CMD_QUERY: state_in = BK_RD0;
                  default:   state_in = BK_NULL;
               endcase
            end
         end
         BK_STORE: begin
            ram_we        = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_height_in = '0;
            rsp_inside_in = 1'b0;
            state_in      = BK_IDLE;
         end
         BK_NULL: begin
            rsp_valid_in  = 1'b1;
            rsp_height_in = '0;
            rsp_inside_in = 1'b0;
            state_in      = BK_IDLE;
         end
         BK_RD0: begin
            state_in = BK_RD1;
         end
         BK_RD1: begin
            ram_x    = 9'(cur_ff.x0) + 9'd1;
            c00_in   = rd_s;
            state_in = BK_RD2;
         end
         BK_RD2: begin
            ram_z    = 9'(cur_ff.z0) + 9'd1;
            diff_in  = DW'(rd_s) - DW'(c00_ff);
            state_in = BK_RD3;
         end
         BK_RD3: begin
            ram_x    = 9'(cur_ff.x0) + 9'd1;
            ram_z    = 9'(cur_ff.z0) + 9'd1;
            c01_in   = rd_s;
            prod_in  = mul_out;
            state_in = BK_BL0;
         end
         BK_BL0: begin
            // Top edge blended; start on the bottom edge.
            diff_in  = DW'(rd_s) - DW'(c01_ff);
            h0_in    = blend_res[HB-1:0];
            state_in = BK_BL1;
         end
         BK_BL1: begin
            prod_in  = mul_out;
            state_in = BK_BL2;
         end
         BK_BL2: begin
            diff_in  = DW'(blend_res) - DW'(h0_ff);
            state_in = BK_BL3;
         end
         BK_BL3: begin
            prod_in  = mul_out;
            state_in = BK_BL4;
         end
         BK_BL4: begin
            rsp_valid_in  = 1'b1;
            rsp_height_in = fin_sat;
            rsp_inside_in = 1'b1;
            state_in      = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_height     = rsp_height_ff;
   assign rsp_inside_res = rsp_inside_ff;

endmodule

// ===== rtl/heightmap_bilinear_sampler_core.sv =====
// Heightmap bilinear sampler, top level. The query rate is bounded by the four corner
// reads through the single-port height memory and the three blend passes on one shared
// multiplier; the back end finishes one command before it takes the next, and writes
// and misses skip the corner reads and blend passes. Synchronous active-high reset
// clears control state and configuration; the height memory is undefined until written.
module heightmap_bilinear_sampler_core import hbs_pkg::*; #(
   parameter int MAX_CELLS   = 255,
   parameter int HEIGHT_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   input  logic signed [23:0]   req_world_x,
   input  logic signed [23:0]   req_world_z,
   input  logic [7:0]           req_grid_x,
   input  logic [7:0]           req_grid_z,
   input  logic signed [23:0]   req_write_height,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [23:0]   rsp_height,
   output logic                 rsp_inside_res,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [23:0]          csr_wdata
);

   localparam int CMD_W = $bits(cmd_type);
   localparam int QW    = CMD_W + HEIGHT_BITS;

   logic [7:0]             grid_res_ff;
   logic [22:0]            half_size_ff;
   logic [23:0]            inv_cell_ff;

   logic                   push, pop, q_empty;
   cmd_type                push_cmd, head_cmd;
   logic [HEIGHT_BITS-1:0] push_wdata, head_wdata;
   logic [QW-1:0]          head_data;
   logic [QCNT_W-1:0]      q_count;

   // Configuration registers; every write is accepted and registered.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_res_ff  <= GRID_RES_RST;
         half_size_ff <= HALF_SIZE_RST;
         inv_cell_ff  <= INV_CELL_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GRID_RES:  grid_res_ff  <= csr_wdata[7:0];
            CSR_HALF_SIZE: half_size_ff <= csr_wdata[22:0];
            CSR_INV_CELL:  inv_cell_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   hbs_front #(
      .MAX_CELLS   (MAX_CELLS),
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_hbs_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_world_x      (req_world_x),
      .req_world_z      (req_world_z),
      .req_grid_x       (req_grid_x),
      .req_grid_z       (req_grid_z),
      .req_write_height (req_write_height),
      .grid_resolution  (grid_res_ff),
      .half_size        (half_size_ff),
      .inv_cell_size    (inv_cell_ff),
      .q_count          (q_count),
      .push             (push),
      .push_cmd         (push_cmd),
      .push_wdata       (push_wdata)
   );

   // Command queue between the two halves.
   hbs_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_hbs_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_cmd, push_wdata}),
      .pop       (pop),
      .head_data (head_data),
      .empty     (q_empty),
      .count     (q_count)
   );

   assign head_cmd   = head_data[QW-1:HEIGHT_BITS];
   assign head_wdata = head_data[HEIGHT_BITS-1:0];

   hbs_back #(
      .MAX_CELLS   (MAX_CELLS),
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_hbs_back (
      .clock          (clock),
      .reset          (reset),
      .head_cmd       (head_cmd),
      .head_wdata     (head_wdata),
      .q_empty        (q_empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_height     (rsp_height),
      .rsp_inside_res (rsp_inside_res)
   );

endmodule

// ===== rtl/hbs_checker.sv =====
// Port-level checker for the heightmap bilinear sampler, bound to the top.
// Depends only on the handshake and result ports of the top level.
module hbs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [23:0] rsp_height,
   input logic               rsp_inside_res
);

   logic [3:0] pend_ff, pend_in;

   // Items accepted whose result beat has not been taken yet.
   assign pend_in = pend_ff + 4'(req_valid && req_ready) - 4'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // A result beat never shows up without an item behind it.
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 4'd0))
      else $error("result beat without an accepted item");

   // A miss or a write always reports height zero.
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_inside_res) |-> (rsp_height == 24'sd0))
      else $error("nonzero height on a result marked outside");

   // Reset leaves no result pending.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_height) && $stable(rsp_inside_res)))
      else $error("stalled result beat changed");

endmodule

bind heightmap_bilinear_sampler_core hbs_checker u_hbs_checker (.*);

// ===== tb/hbs_height_checker.sv =====
// Prediction and result checking for the heightmap bilinear sampler testbench.
// Holds a small package of grid mapping helpers shared with the stimulus side.
// Depends on hbs_pkg from the RTL.
`timescale 1ns / 100ps

package hbs_tb_pkg;

   // One expected result beat.
   typedef struct packed {
      logic signed [23:0] height;
      logic               on_grid;
   } height_result_type;

   // Maps one world axis to a Q.8 grid coordinate. Returns 0 when the point is off the grid.
   function automatic bit axis_to_grid(input logic signed [23:0] world,
                                       input logic [7:0] res,
                                       input logic [22:0] half,
                                       input logic [23:0] inv,
                                       output logic [15:0] g);
      longint sum;
      longint v;
      g = '0;
      sum = longint'(world) + longint'(half);
      if (sum < 0) begin
         // With a zero reciprocal every point collapses onto grid origin.
         if (inv != 0) return 1'b0;
         v = 0;
      end else begin
         v = (sum * longint'(inv)) >>> 16;
      end
      if (v >= (longint'(res) << 8)) return 1'b0;
      g = v[15:0];
      return 1'b1;
   endfunction

endpackage

module hbs_height_checker import hbs_pkg::*, hbs_tb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 req_op,
   input  logic signed [23:0]   req_world_x,
   input  logic signed [23:0]   req_world_z,
   input  logic [7:0]           req_grid_x,
   input  logic [7:0]           req_grid_z,
   input  logic signed [23:0]   req_write_height,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic signed [23:0]   rsp_height,
   input  logic                 rsp_inside_res,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [23:0]          csr_wdata,
   output int                   mismatch_count,
   output int                   outstanding,
   output int                   blended_count
);

   localparam int MAX_REPORTS = 10;

   // Shadow copy of the block's registers and height memory.
   logic [7:0]         grid_res;
   logic [22:0]        half_size;
   logic [23:0]        inv_cell;
   logic signed [23:0] height_mem [0:65535];

   height_result_type expected_q [$];
   height_result_type want;
   int                errors = 0;
   int                n_blended = 0;
   int                n_results = 0;

   // Linear blend with round-half-up and floor division by 256.
   function automatic longint lerp_q8(input longint a, input longint b, input logic [7:0] f);
      return a + ((longint'(f) * (b - a) + 128) >>> 8);
   endfunction

   // Expected answer of a query beat against the current shadow state.
   function automatic height_result_type predict_height(input logic signed [23:0] wx,
                                                        input logic signed [23:0] wz);
      height_result_type r;
      logic [15:0]       gx;
      logic [15:0]       gz;
      logic [7:0]        x0;
      logic [7:0]        z0;
      longint            row0;
      longint            row1;
      longint            h;
      r.height  = '0;
      r.on_grid = 1'b0;
      if (!axis_to_grid(wx, grid_res, half_size, inv_cell, gx) ||
          !axis_to_grid(wz, grid_res, half_size, inv_cell, gz))
         return r;
      x0 = gx[15:8];
      z0 = gz[15:8];
      // Blend along x on both rows, then along z.
      row0 = lerp_q8(longint'(height_mem[{z0, x0}]),
                     longint'(height_mem[{z0, x0 + 8'd1}]), gx[7:0]);
      row1 = lerp_q8(longint'(height_mem[{z0 + 8'd1, x0}]),
                     longint'(height_mem[{z0 + 8'd1, x0 + 8'd1}]), gx[7:0]);
      h = lerp_q8(row0, row1, gz[7:0]);
      if (h > OUT_MAX) h = OUT_MAX;
      if (h < OUT_MIN) h = OUT_MIN;
      r.height  = h[23:0];
      r.on_grid = 1'b1;
      return r;
   endfunction

   // Watch all three channels at each edge: registers, results, then new requests.
   always @(posedge clock) begin
      if (reset) begin
         grid_res  = GRID_RES_RST;
         half_size = HALF_SIZE_RST;
         inv_cell  = INV_CELL_RST;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GRID_RES:  grid_res  = csr_wdata[7:0];
               CSR_HALF_SIZE: half_size = csr_wdata[22:0];
               CSR_INV_CELL:  inv_cell  = csr_wdata;
               default: ;
            endcase
         end

         // Compare each result beat with the oldest expectation.
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("Result beat %0d arrived with nothing expected: height %0d inside %0b",
                           n_results, rsp_height, rsp_inside_res);
            end else begin
               want = expected_q.pop_front();
               if (rsp_height !== want.height) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("Result beat %0d height: expected %0d, got %0d",
                              n_results, want.height, rsp_height);
               end
               if (rsp_inside_res !== want.on_grid) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("Result beat %0d inside flag: expected %0b, got %0b",
                              n_results, want.on_grid, rsp_inside_res);
               end
            end
            n_results++;
         end

         // Predict the answer of each request beat in acceptance order.
         if (req_valid && req_ready) begin
            if (req_op == OP_WRITE) begin
               if (req_grid_x <= grid_res && req_grid_z <= grid_res)
                  height_mem[{req_grid_z, req_grid_x}] = req_write_height;
               want.height  = '0;
               want.on_grid = 1'b0;
            end else begin
               want = predict_height(req_world_x, req_world_z);
               if (want.on_grid) n_blended++;
            end
            expected_q.insert(expected_q.size(), want);
         end
      end
      mismatch_count <= errors;
      outstanding    <= expected_q.size();
      blended_count  <= n_blended;
   end

endmodule

// ===== tb/tb_heightmap_bilinear_sampler_core.sv =====
// Top of the heightmap bilinear sampler testbench: clock, reset, stimulus and verdict.
// Depends on hbs_pkg, the block itself and hbs_height_checker with its helper package.
`timescale 1ns / 100ps

module tb_heightmap_bilinear_sampler_core;
   import hbs_pkg::*;
   import hbs_tb_pkg::*;

   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_TAIL     = 16;
   // Longest legal quiet stretch is the receiver hold-off plus one query latency.
   localparam int WATCHDOG_LIMIT = 5000;
   localparam logic signed [23:0] HEIGHT_MAX = 24'(OUT_MAX);
   localparam logic signed [23:0] HEIGHT_MIN = 24'(OUT_MIN);

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_op = OP_QUERY;
   logic signed [23:0]   req_world_x = '0;
   logic signed [23:0]   req_world_z = '0;
   logic [7:0]           req_grid_x = '0;
   logic [7:0]           req_grid_z = '0;
   logic signed [23:0]   req_write_height = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [23:0]   rsp_height;
   logic                 rsp_inside_res;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_GRID_RES;
   logic [23:0]          csr_wdata = '0;

   int mismatch_count;
   int outstanding;
   int blended_count;

   // Stimulus-side view of the registers and of which grid points hold a height.
   logic [7:0]  cfg_res  = GRID_RES_RST;
   logic [22:0] cfg_half = HALF_SIZE_RST;
   logic [23:0] cfg_inv  = INV_CELL_RST;
   bit          written [0:65535];

   bit calm = 1'b0;
   int hold_req = 0;
   int hold_done = 0;
   int n_writes = 0;
   int n_ignored = 0;
   int n_queries = 0;
   int n_settings = 0;
   int quiet_cycles = 0;

   always #4 clock = ~clock;

   heightmap_bilinear_sampler_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_world_x     (req_world_x),
      .req_world_z     (req_world_z),
      .req_grid_x      (req_grid_x),
      .req_grid_z      (req_grid_z),
      .req_write_height(req_write_height),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_height      (rsp_height),
      .rsp_inside_res  (rsp_inside_res),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   hbs_height_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_world_x     (req_world_x),
      .req_world_z     (req_world_z),
      .req_grid_x      (req_grid_x),
      .req_grid_z      (req_grid_z),
      .req_write_height(req_write_height),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_height      (rsp_height),
      .rsp_inside_res  (rsp_inside_res),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .outstanding     (outstanding),
      .blended_count   (blended_count)
   );

   // Result receiver: random back-pressure, or a long hold-off when one is requested.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req != hold_done) begin
            hold_done = hold_req;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 15);
         end
      end
   end

   // Watchdog on cycles in which no beat moves on any channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no beat for %0d cycles, %0d results still expected",
                  quiet_cycles, outstanding);
         $display("[heightmap_bilinear_sampler_core] ERROR");
         $finish;
      end
   end

   // Offers one request beat and holds it until accepted; may then idle at random.
   task automatic issue_item(input logic op, input logic signed [23:0] wx,
                             input logic signed [23:0] wz, input logic [7:0] gx,
                             input logic [7:0] gz, input logic signed [23:0] hgt);
      req_valid        <= 1'b1;
      req_op           <= op;
      req_world_x      <= wx;
      req_world_z      <= wz;
      req_grid_x       <= gx;
      req_grid_z       <= gz;
      req_write_height <= hgt;
      do @(posedge clock); while (!req_ready);
      if (op == OP_WRITE) begin
         if (gx <= cfg_res && gz <= cfg_res) begin
            written[{gz, gx}] = 1'b1;
            n_writes++;
         end else begin
            n_ignored++;
         end
      end else begin
         n_queries++;
      end
      if (!calm && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   endtask

   function automatic logic signed [23:0] rand_height();
      case ($urandom_range(9))
         0: return HEIGHT_MAX;
         1: return HEIGHT_MIN;
         2: return '0;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic write_point(input logic [7:0] gx, input logic [7:0] gz,
                              input logic signed [23:0] hgt);
      issue_item(OP_WRITE, 24'($urandom), 24'($urandom), gx, gz, hgt);
   endtask

   // A query beat, preceded by writes to any of its four corners that hold no height yet.
   task automatic issue_query(input logic signed [23:0] wx, input logic signed [23:0] wz);
      logic [15:0] gx;
      logic [15:0] gz;
      logic [7:0]  cx;
      logic [7:0]  cz;
      if (axis_to_grid(wx, cfg_res, cfg_half, cfg_inv, gx) &&
          axis_to_grid(wz, cfg_res, cfg_half, cfg_inv, gz)) begin
         for (int dz = 0; dz < 2; dz++) begin
            for (int dx = 0; dx < 2; dx++) begin
               cx = gx[15:8] + 8'(dx);
               cz = gz[15:8] + 8'(dz);
               if (!written[{cz, cx}]) write_point(cx, cz, rand_height());
            end
         end
      end
      issue_item(OP_QUERY, wx, wz, 8'($urandom), 8'($urandom), 24'($urandom));
   endtask

   // World coordinate aimed near or across the grid under the current setting.
   function automatic logic signed [23:0] pick_world();
      longint target;
      longint w;
      if ($urandom_range(9) == 0) return 24'($urandom);
      target = longint'($urandom_range(int'(cfg_res) * 256 + 63)) - 32;
      if (cfg_inv == 0)
         w = target - longint'(cfg_half);
      else
         w = (target * 65536) / longint'(cfg_inv) - longint'(cfg_half)
             + longint'($urandom_range(4)) - 2;
      if (w > OUT_MAX) w = OUT_MAX;
      if (w < OUT_MIN) w = OUT_MIN;
      return w[23:0];
   endfunction

   task automatic random_write();
      logic [7:0] gx;
      logic [7:0] gz;
      if ($urandom_range(9) < 7) begin
         gx = 8'($urandom_range(cfg_res));
         gz = 8'($urandom_range(cfg_res));
      end else begin
         gx = 8'($urandom);
         gz = 8'($urandom);
      end
      write_point(gx, gz, rand_height());
   endtask

   // Stops offering and waits until every expected result has been seen.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   // Writes all three registers back to back while the block is idle.
   task automatic apply_setting(input logic [23:0] res_w, input logic [23:0] half_w,
                                input logic [23:0] inv_w);
      logic [CSR_IDX_W-1:0] idx_list [3];
      logic [23:0]          val_list [3];
      idx_list = '{CSR_GRID_RES, CSR_HALF_SIZE, CSR_INV_CELL};
      val_list = '{res_w, half_w, inv_w};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx_list[i];
         csr_wdata <= val_list[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      cfg_res  = res_w[7:0];
      cfg_half = half_w[22:0];
      cfg_inv  = inv_w;
      n_settings++;
   endtask

   // One register setting followed by a mix of writes and corner-safe queries.
   task automatic run_phase(input logic [23:0] res_w, input logic [23:0] half_w,
                            input logic [23:0] inv_w, input int n_items, input bit quiet,
                            input int hold_at, input int pause_at);
      wait_drained();
      apply_setting(res_w, half_w, inv_w);
      calm = quiet;
      for (int k = 0; k < n_items; k++) begin
         if (k == hold_at) hold_req++;
         if (k == pause_at) wait_drained();
         if ($urandom_range(99) < 35)
            random_write();
         else
            issue_query(pick_world(), pick_world());
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset setting maps 256 world units to one cell of a 255-cell grid.
      write_point(8'd0, 8'd0, HEIGHT_MAX);
      write_point(8'd1, 8'd0, HEIGHT_MIN);
      write_point(8'd0, 8'd1, '0);
      write_point(8'd1, 8'd1, -24'sd1);
      issue_query(24'sd0, 24'sd0);
      issue_query(24'sd128, 24'sd128);
      issue_query(24'sd255, 24'sd1);
      issue_query(24'sd255, 24'sd255);
      write_point(8'd255, 8'd255, HEIGHT_MAX);
      write_point(8'd254, 8'd254, HEIGHT_MIN);
      write_point(8'd255, 8'd254, 24'sd256);
      write_point(8'd254, 8'd255, -24'sd256);
      // Top edge just inside, then just past it, then below zero and the field extremes.
      issue_query(24'sd65279, 24'sd65279);
      issue_query(24'sd65280, 24'sd0);
      issue_query(24'sd0, 24'sd65280);
      issue_query(-24'sd1, 24'sd0);
      issue_query(HEIGHT_MIN, HEIGHT_MAX);
      issue_query(24'sd65279, 24'sd0);

      // Small grid with many off-grid writes; receiver hold-off fills the block.
      run_phase(24'd4, 24'd512, 24'd65536, 110, 1'b0, 40, -1);
      // Largest half size with the smallest nonzero reciprocal; sender drains mid-phase.
      run_phase(24'd255, 24'h7FFFFF, 24'd1, 100, 1'b0, -1, 50);
      // Single cell at full-scale reciprocal, no idling on either side.
      run_phase(24'd1, 24'd0, 24'hFFFFFF, 100, 1'b1, -1, -1);
      // Zero resolution, with junk above the register width.
      run_phase(24'hA55A00, 24'hFFFFFF, 24'd65536, 60, 1'b0, -1, -1);
      // Zero reciprocal collapses every point onto the origin cell.
      run_phase(24'd16, 24'h001234, 24'd0, 80, 1'b0, -1, -1);
      run_phase(24'd200, 24'h812345, 24'd32768, 50, 1'b0, 25, -1);
      // Random settings.
      repeat (2) begin
         run_phase(24'($urandom_range(255)), 24'($urandom),
                   24'($urandom_range(262143, 8192)), 50, 1'b0, -1, -1);
      end

      wait_drained();
      $display("Covered %0d stored writes, %0d off-grid writes and %0d queries (%0d blended)",
               n_writes, n_ignored, n_queries, blended_count);
      $display("across %0d register settings, with a receiver hold-off and a full drain pause.",
               n_settings + 1);
      if (mismatch_count == 0 && outstanding == 0)
         $display("[heightmap_bilinear_sampler_core] OK");
      else
         $display("[heightmap_bilinear_sampler_core] ERROR");
      $finish;
   end

endmodule
